### src/sfr_pkg.sv
// Shared types and constants for the serial frame receiver.
package sfr_pkg;

  // Default number of priority levels that keep a last-seen id.
  localparam int LEVELS_DEF = 4;

  // Start-of-frame marker byte.
  localparam logic [7:0] START_BYTE = 8'hFF;

  // Result kind codes.
  localparam logic [1:0] KIND_PAYLOAD  = 2'd0;
  localparam logic [1:0] KIND_ACCEPT   = 2'd1;
  localparam logic [1:0] KIND_MISMATCH = 2'd2;

  // Frame type codes from the control byte.
  localparam logic [1:0] TYPE_RELIABLE = 2'd0;
  localparam logic [1:0] TYPE_PLAIN    = 2'd1;

  // Parser phases, one-hot.
  typedef enum logic [5:0] {
    PH_HUNT   = 6'b000001,
    PH_LEN_HI = 6'b000010,
    PH_LEN_LO = 6'b000100,
    PH_CTRL   = 6'b001000,
    PH_ID     = 6'b010000,
    PH_BODY   = 6'b100000
  } phase_t;

  // One result item.
  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  data_byte;
    logic [1:0]  frame_type;
    logic [3:0]  port_number;
    logic [1:0]  priority_level;
    logic [7:0]  frame_id;
    logic [15:0] payload_length;
    logic        duplicate;
    logic        deliver;
    logic        ack_request;
  } result_t;

  // Access from the parser to the last-id memory.
  typedef struct packed {
    logic       rd_en;
    logic       wr_en;
    logic [1:0] level;
    logic [7:0] wr_id;
  } mem_req_t;

endpackage

### src/sfr_id_mem.sv
// Last-seen id memory, one entry per priority level, with per-entry valid bits.
module sfr_id_mem #(
  parameter int LEVELS = sfr_pkg::LEVELS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  sfr_pkg::mem_req_t req,
  output logic [7:0]       rd_id
);
  import sfr_pkg::*;

  localparam int AW = (LEVELS > 2) ? 2 : 1;

  logic [7:0]        mem_r [LEVELS];
  logic [LEVELS-1:0] vld_r;
  logic [7:0]        rd_data_r;
  logic              rd_vld_r;
  logic [AW-1:0]     idx;

  assign idx = req.level[AW-1:0];

  // Storage array and registered read port.
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem_r[idx] <= req.wr_id;
    end
    if (req.rd_en) begin
      rd_data_r <= mem_r[idx];
    end
  end

  // Valid bits: an entry never written reads as zero.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (req.wr_en) begin
        vld_r[idx] <= 1'b1;
      end
      if (req.rd_en) begin
        rd_vld_r <= vld_r[idx];
      end
    end
  end

  assign rd_id = rd_vld_r ? rd_data_r : 8'd0;

endmodule

### src/sfr_parser.sv
// Frame parser: phase tracking, length count, checksum and verdict.
module sfr_parser #(
  parameter int LEVELS = sfr_pkg::LEVELS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_fire,
  input  logic [7:0]        rx_byte,
  input  logic [7:0]        rd_id,
  output logic              res_valid,
  output sfr_pkg::result_t  res,
  output sfr_pkg::mem_req_t mem_req
);
  import sfr_pkg::*;

  phase_t      phase_r, phase_nxt;
  logic [15:0] len_r, len_nxt;
  logic [15:0] cnt_r, cnt_nxt;
  logic [7:0]  sum_r, sum_nxt;
  logic [1:0]  type_r, type_nxt;
  logic [3:0]  port_r, port_nxt;
  logic [1:0]  level_r, level_nxt;
  logic [7:0]  id_r, id_nxt;
  logic        in_range;
  logic        sum_ok;
  logic        dup;

  assign in_range = ({1'b0, level_r} < 3'(LEVELS));
  assign sum_ok   = (sum_r == rx_byte);
  assign dup      = (type_r == TYPE_RELIABLE) && in_range && (rd_id == id_r);

  // Next-state, result and memory access for one accepted byte.
  always_comb begin
    phase_nxt = phase_r;
    len_nxt   = len_r;
    cnt_nxt   = cnt_r;
    sum_nxt   = sum_r;
    type_nxt  = type_r;
    port_nxt  = port_r;
    level_nxt = level_r;
    id_nxt    = id_r;
    res_valid = 1'b0;
    res       = '0;
    mem_req   = '0;
    mem_req.level = level_r;
    mem_req.wr_id = id_r;
    if (in_fire) begin
      case (phase_r)
        PH_HUNT: begin
          if (rx_byte == START_BYTE) begin
            phase_nxt = PH_LEN_HI;
          end
        end
        PH_LEN_HI: begin
          len_nxt   = {rx_byte, 8'd0};
          phase_nxt = PH_LEN_LO;
        end
        PH_LEN_LO: begin
          len_nxt   = {len_r[15:8], rx_byte};
          phase_nxt = PH_CTRL;
        end
        PH_CTRL: begin
          type_nxt  = rx_byte[7:6];
          level_nxt = rx_byte[5:4];
          port_nxt  = rx_byte[3:0];
          phase_nxt = PH_ID;
        end
        PH_ID: begin
          id_nxt         = rx_byte;
          mem_req.rd_en  = in_range;
          phase_nxt      = PH_BODY;
        end
        PH_BODY: begin
          res_valid = 1'b1;
          if (cnt_r < len_r) begin
            // Payload byte: pass it on and fold it into the checksum.
            sum_nxt       = sum_r + rx_byte;
            cnt_nxt       = cnt_r + 16'd1;
            res.kind      = KIND_PAYLOAD;
            res.data_byte = rx_byte;
          end else begin
            // Checksum byte: give the verdict and return to hunting.
            res.frame_type     = type_r;
            res.port_number    = port_r;
            res.priority_level = level_r;
            res.frame_id       = id_r;
            res.payload_length = len_r;
            if (sum_ok) begin
              res.kind        = KIND_ACCEPT;
              res.duplicate   = dup;
              res.deliver     = (type_r == TYPE_PLAIN) ||
                                ((type_r == TYPE_RELIABLE) && !dup);
              res.ack_request = (type_r == TYPE_RELIABLE);
              mem_req.wr_en   = in_range;
            end else begin
              res.kind = KIND_MISMATCH;
            end
            phase_nxt = PH_HUNT;
            len_nxt   = '0;
            cnt_nxt   = '0;
            sum_nxt   = '0;
            type_nxt  = '0;
            port_nxt  = '0;
            level_nxt = '0;
          end
        end
        default: begin
          phase_nxt = PH_HUNT;
          len_nxt   = '0;
          cnt_nxt   = '0;
          sum_nxt   = '0;
          type_nxt  = '0;
          port_nxt  = '0;
          level_nxt = '0;
        end
      endcase
    end
  end

  // Parser registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HUNT;
      len_r   <= '0;
      cnt_r   <= '0;
      sum_r   <= '0;
      type_r  <= '0;
      port_r  <= '0;
      level_r <= '0;
      id_r    <= '0;
    end else begin
      phase_r <= phase_nxt;
      len_r   <= len_nxt;
      cnt_r   <= cnt_nxt;
      sum_r   <= sum_nxt;
      type_r  <= type_nxt;
      port_r  <= port_nxt;
      level_r <= level_nxt;
      id_r    <= id_nxt;
    end
  end

`ifndef SYNTHESIS
  // A payload item comes only from the body phase.
  a_payload_in_body: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && res.kind == KIND_PAYLOAD) |-> (phase_r == PH_BODY))
    else $error("payload item outside body phase");

  // Every verdict sends the parser back to hunting.
  a_verdict_ends_frame: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && res.kind != KIND_PAYLOAD) |=> (phase_r == PH_HUNT))
    else $error("parser did not return to hunting after a verdict");

  // The id memory is written only for an accepted frame.
  a_write_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
    mem_req.wr_en |-> (res_valid && res.kind == KIND_ACCEPT))
    else $error("id memory written without an accepted frame");

  // The id memory is read only as the frame body begins.
  a_read_then_body: assert property (@(posedge clk) disable iff (!rst_n)
    mem_req.rd_en |=> (phase_r == PH_BODY && cnt_r == 16'd0))
    else $error("id memory read outside frame start");
`endif

endmodule

### src/sfr_out_buf.sv
// Two-entry result queue between the parser and the output channel.
module sfr_out_buf (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  sfr_pkg::result_t push_item,
  output logic             not_full,
  output logic             out_valid,
  input  logic             out_ready,
  output sfr_pkg::result_t head_item
);
  import sfr_pkg::*;

  result_t    ent_r [2];
  logic       head_r, head_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       pop;
  logic       wr_slot;

  assign out_valid = (cnt_r != 2'd0);
  assign not_full  = (cnt_r != 2'd2);
  assign pop       = out_valid && out_ready;
  assign wr_slot   = head_r ^ cnt_r[0];
  assign head_item = ent_r[head_r];

  // Queue pointers.
  always_comb begin
    head_nxt = pop ? ~head_r : head_r;
    cnt_nxt  = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      head_r <= head_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_slot] <= push_item;
    end
  end

`ifndef SYNTHESIS
  // The count never exceeds the two entries.
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd3)
    else $error("result queue count out of range");

  // A lone push grows the queue by one item.
  a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> (cnt_r == $past(cnt_r) + 2'd1))
    else $error("result queue lost a pushed item");

  // A lone pop shrinks the queue and advances the head.
  a_pop_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && !push) |=> (cnt_r == $past(cnt_r) - 2'd1 && head_r != $past(head_r)))
    else $error("result queue pop mishandled");
`endif

endmodule

### src/serial_frame_receiver.sv
// Top level of the serial frame receiver.
// The receiver takes one byte per clock cycle on the input channel and answers
// each payload byte and each checksum byte with one result item, registered in
// the output queue; start, length, control and id bytes yield nothing. Input
// ready stays high while fewer than two result items wait in the output queue,
// so a stalled output side holds back the input only once two results are
// queued. The last-seen id of each priority level sits in a small memory with
// a registered read, issued when the id byte is taken so its data is ready by
// the earliest possible checksum byte; it is written on every frame with a good
// checksum and an in-range level. No clearing pass is needed after reset.
module serial_frame_receiver #(
  parameter int LEVELS = sfr_pkg::LEVELS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_kind,
  output logic [7:0]  out_data_byte,
  output logic [1:0]  out_frame_type,
  output logic [3:0]  out_port_number,
  output logic [1:0]  out_priority_level,
  output logic [7:0]  out_frame_id,
  output logic [15:0] out_payload_length,
  output logic        out_duplicate,
  output logic        out_deliver,
  output logic        out_ack_request
);
  import sfr_pkg::*;

  logic     in_fire;
  logic     res_valid;
  result_t  res;
  result_t  head_item;
  mem_req_t mem_req;
  logic [7:0] rd_id;

  assign in_fire = in_valid && in_ready;

  // Byte parser and verdict logic.
  sfr_parser #(.LEVELS(LEVELS)) u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_fire   (in_fire),
    .rx_byte   (in_rx_byte),
    .rd_id     (rd_id),
    .res_valid (res_valid),
    .res       (res),
    .mem_req   (mem_req)
  );

  // Last-seen id per level.
  sfr_id_mem #(.LEVELS(LEVELS)) u_id_mem (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mem_req),
    .rd_id (rd_id)
  );

  // Result queue toward the output channel.
  sfr_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_fire && res_valid),
    .push_item (res),
    .not_full  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .head_item (head_item)
  );

  // Output fields.
  assign out_kind           = head_item.kind;
  assign out_data_byte      = head_item.data_byte;
  assign out_frame_type     = head_item.frame_type;
  assign out_port_number    = head_item.port_number;
  assign out_priority_level = head_item.priority_level;
  assign out_frame_id       = head_item.frame_id;
  assign out_payload_length = head_item.payload_length;
  assign out_duplicate      = head_item.duplicate;
  assign out_deliver        = head_item.deliver;
  assign out_ack_request    = head_item.ack_request;

endmodule
